// ===== sv/fupa_pkg.sv =====
// Shared types, codes and reset values of the fixed unit pool allocator.
`timescale 1ns / 1ps
`default_nettype none

package fupa_pkg;

  localparam int MAX_UNITS_DEF = 256;

  localparam logic [8:0] UPB_RESET = 9'd16;
  localparam logic       EXPAND_RESET = 1'b0;

  typedef enum logic {
    OP_ALLOC = 1'b0,
    OP_FREE  = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NO_SPACE = 2'd1,
    ST_BAD_UNIT = 2'd2
  } status_t;

  typedef enum logic {
    REG_UNITS_PER_BLOCK = 1'b0,
    REG_EXPAND_ENABLE   = 1'b1
  } reg_idx_t;

  typedef struct packed {
    logic [8:0] units_per_block;
    logic       expand_enable;
  } cfg_regs_t;

  // Packed so that granted_unit sits in the lowest bits.
  typedef struct packed {
    logic [8:0] used_count;
    logic [8:0] block_count;
    status_t    status;
    logic [7:0] granted_unit;
  } res_t;

  typedef struct packed {
    logic push;
    logic pop;
  } stk_cmd_t;

endpackage

`default_nettype wire

// ===== sv/fupa_cfg.sv =====
// Configuration register file behind the APB-style port.
`timescale 1ns / 1ps
`default_nettype none

module fupa_cfg
  import fupa_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic        reg_sel,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output cfg_regs_t        cfg
);

  cfg_regs_t cfg_r;
  cfg_regs_t cfg_nxt;
  logic      wr_en;

  assign wr_en = psel && penable && pwrite;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (reg_idx_t'(reg_sel))
        REG_UNITS_PER_BLOCK: cfg_nxt.units_per_block = pwdata[8:0];
        REG_EXPAND_ENABLE:   cfg_nxt.expand_enable = pwdata[0];
        default:             cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.units_per_block <= UPB_RESET;
      cfg_r.expand_enable   <= EXPAND_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  always_comb begin
    unique case (reg_idx_t'(reg_sel))
      REG_UNITS_PER_BLOCK: prdata = {23'd0, cfg_r.units_per_block};
      REG_EXPAND_ENABLE:   prdata = {31'd0, cfg_r.expand_enable};
      default:             prdata = 32'd0;
    endcase
  end

  assign cfg = cfg_r;

endmodule

`default_nettype wire

// ===== sv/fupa_stack.sv =====
// Free-unit stack: top and the entry below it in registers, the rest in a memory.
`timescale 1ns / 1ps
`default_nettype none

module fupa_stack
  import fupa_pkg::*;
#(
  parameter int MAX_UNITS = MAX_UNITS_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire stk_cmd_t                     cmd,
  input  wire logic [$clog2(MAX_UNITS)-1:0] push_unit,
  output logic      [$clog2(MAX_UNITS)-1:0] top,
  output logic                              nonempty
);

  localparam int UW = $clog2(MAX_UNITS);
  localparam int CW = $clog2(MAX_UNITS + 1);

  logic [UW-1:0] mem [MAX_UNITS];
  logic [CW-1:0] cnt_r;
  logic [CW-1:0] cnt_nxt;
  logic [UW-1:0] top_r;
  logic [UW-1:0] below_r;
  logic [UW-1:0] wr_idx;
  logic [UW-1:0] rd_idx;
  logic [CW-1:0] wr_pos;
  logic [CW-1:0] rd_pos;

  // The old top moves down into the memory on a push; a pop takes the
  // registered entry below as new top and fetches the one under it.
  assign wr_pos = cnt_r - CW'(1);
  assign rd_pos = cnt_r - CW'(3);
  assign wr_idx = wr_pos[UW-1:0];
  assign rd_idx = rd_pos[UW-1:0];

  always_comb begin
    cnt_nxt = cnt_r;
    if (cmd.push) begin
      cnt_nxt = cnt_r + CW'(1);
    end else if (cmd.pop) begin
      cnt_nxt = cnt_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      if (cnt_r != '0) begin
        mem[wr_idx] <= top_r;
      end
      below_r <= top_r;
      top_r   <= push_unit;
    end else if (cmd.pop) begin
      if (cnt_r >= CW'(3)) begin
        below_r <= mem[rd_idx];
      end
      top_r <= below_r;
    end
  end

  assign top      = top_r;
  assign nonempty = (cnt_r != '0);

endmodule

`default_nettype wire

// ===== sv/fupa_alloc.sv =====
// Allocation decision and pool bookkeeping, one word per cycle on fire.
`timescale 1ns / 1ps
`default_nettype none

module fupa_alloc
  import fupa_pkg::*;
#(
  parameter int MAX_UNITS = MAX_UNITS_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         fire,
  input  wire op_t                          op,
  input  wire logic [7:0]                   handle,
  input  wire cfg_regs_t                    cfg,
  input  wire logic [$clog2(MAX_UNITS)-1:0] stk_top,
  input  wire logic                         stk_nonempty,
  output res_t                              res,
  output stk_cmd_t                          stk_cmd,
  output logic      [$clog2(MAX_UNITS)-1:0] push_unit
);

  localparam int UW = $clog2(MAX_UNITS);
  localparam int CW = $clog2(MAX_UNITS + 1);
  localparam int PW = 2 * CW;
  localparam logic [31:0] MAX_W = 32'(MAX_UNITS);
  localparam logic [PW:0] MAX_P = (PW + 1)'(MAX_UNITS);
  localparam logic [CW-1:0] MAX_C = CW'(MAX_UNITS);

  logic [MAX_UNITS-1:0] in_use_r;
  logic [MAX_UNITS-1:0] in_use_nxt;
  logic [CW-1:0]        fresh_r;
  logic [CW-1:0]        fresh_nxt;
  logic [CW-1:0]        grown_r;
  logic [CW-1:0]        grown_nxt;
  logic [CW-1:0]        used_r;
  logic [CW-1:0]        used_nxt;

  logic [31:0]   upb_w;
  logic [CW-1:0] bs;
  logic [PW-1:0] limit;
  logic [PW:0]   grow_limit;
  logic          fresh_ok;
  logic          grow_ok;
  logic          handle_hi;
  logic [UW-1:0] handle_idx;
  logic [UW-1:0] fresh_idx;
  logic          free_ok;
  logic [UW-1:0] unit;
  status_t       status;

  // Block size clamped to the range one to MAX_UNITS.
  assign upb_w = 32'(cfg.units_per_block);
  always_comb begin
    if (upb_w == 32'd0) begin
      bs = CW'(1);
    end else if (upb_w > MAX_W) begin
      bs = MAX_C;
    end else begin
      bs = CW'(upb_w);
    end
  end

  assign limit      = PW'(grown_r) * PW'(bs);
  assign grow_limit = (PW + 1)'(limit) + (PW + 1)'(bs);
  assign fresh_ok   = (PW'(fresh_r) < limit) && (fresh_r < MAX_C);
  assign grow_ok    = cfg.expand_enable && (grow_limit <= MAX_P) &&
                      (grow_limit > (PW + 1)'(fresh_r));

  assign handle_hi  = (32'(handle) >= MAX_W);
  assign handle_idx = UW'(handle);
  assign fresh_idx  = fresh_r[UW-1:0];
  assign free_ok    = handle_hi ? 1'b0 : in_use_r[handle_idx];

  always_comb begin
    in_use_nxt = in_use_r;
    fresh_nxt  = fresh_r;
    grown_nxt  = grown_r;
    used_nxt   = used_r;
    stk_cmd    = '0;
    unit       = '0;
    status     = ST_OK;
    unique case (op)
      OP_ALLOC: begin
        priority if (stk_nonempty) begin
          unit         = stk_top;
          stk_cmd.pop  = fire;
          in_use_nxt[stk_top] = 1'b1;
          used_nxt     = used_r + CW'(1);
        end else if (fresh_ok || grow_ok) begin
          unit         = fresh_idx;
          in_use_nxt[fresh_idx] = 1'b1;
          used_nxt     = used_r + CW'(1);
          fresh_nxt    = fresh_r + CW'(1);
          if (!fresh_ok) begin
            grown_nxt = grown_r + CW'(1);
          end
        end else begin
          status = ST_NO_SPACE;
        end
      end
      OP_FREE: begin
        unit = handle_idx;
        if (free_ok) begin
          stk_cmd.push = fire;
          in_use_nxt[handle_idx] = 1'b0;
          used_nxt     = used_r - CW'(1);
        end else begin
          status = ST_BAD_UNIT;
        end
      end
      default: status = ST_BAD_UNIT;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_use_r <= '0;
      fresh_r  <= '0;
      grown_r  <= CW'(1);
      used_r   <= '0;
    end else if (fire) begin
      in_use_r <= in_use_nxt;
      fresh_r  <= fresh_nxt;
      grown_r  <= grown_nxt;
      used_r   <= used_nxt;
    end
  end

  assign push_unit = handle_idx;

  // On a free the handle itself is echoed, including handles out of range.
  always_comb begin
    res.granted_unit = (op == OP_FREE) ? handle : 8'(unit);
    res.status       = status;
    res.block_count  = 9'(grown_nxt);
    res.used_count   = 9'(used_nxt);
  end

endmodule

`default_nettype wire

// ===== sv/fixed_unit_pool_allocator.sv =====
// Fixed unit pool allocator: top level with input and result registers.
//
// Each input word carries an opcode in in_tuser (0 allocate, 1 free) and a
// unit handle in in_tdata. Every word produces exactly one result word on
// the out_ channel holding the granted unit, a status code, the number of
// blocks in the pool and the number of units in use after that word.
// Freed units are handed out again most recent first; otherwise the lowest
// never-used unit is granted, growing the pool by one block when allowed.
//
// A result becomes valid once the accepting edge has loaded the input register
// and a single pass through the allocation logic has loaded the result register.
// One word is accepted per cycle, sustained while the receiver does not stall,
// because the free stack keeps its top and the entry below in registers and
// refills the lower one from its memory on the same edge as a pop.
// When the receiver stalls the result is held and the input register fills;
// in_tready drops only when both stages are occupied.
// After reset the pool has one block, no unit is in use, the free stack is
// empty and the registers hold 16 units per block with growth disabled.
// The user must write configuration through the cfg_ port only while no word
// is in flight; the block itself does not enforce this.
`timescale 1ns / 1ps
`default_nettype none

module fixed_unit_pool_allocator
  import fupa_pkg::*;
#(
  parameter int MAX_UNITS = MAX_UNITS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,     // [7:0] unit_handle
  input  wire logic        in_tuser,     // [0] opcode
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic      [31:0] out_tdata,    // [7:0] granted_unit, [9:8] status,
                                         // [18:10] block_count, [27:19] used_count
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [2:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic      [31:0] cfg_prdata,
  output logic             cfg_pready
);

  localparam int UW = $clog2(MAX_UNITS);

  logic       s1_valid_r;
  logic       s1_valid_nxt;
  op_t        s1_op_r;
  logic [7:0] s1_handle_r;
  logic       out_valid_r;
  logic       out_valid_nxt;
  res_t       out_res_r;

  logic      advance;
  logic      fire;
  logic      in_fire;
  cfg_regs_t cfg;
  res_t      res;
  stk_cmd_t  stk_cmd;
  logic [UW-1:0] stk_top;
  logic [UW-1:0] push_unit;
  logic          stk_nonempty;

  assign advance   = !out_valid_r || out_tready;
  assign fire      = s1_valid_r && advance;
  assign in_tready = !s1_valid_r || advance;
  assign in_fire   = in_tvalid && in_tready;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_fire) begin
      s1_valid_nxt = 1'b1;
    end else if (fire) begin
      s1_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (advance) begin
      out_valid_nxt = fire;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_op_r     <= op_t'(in_tuser);
      s1_handle_r <= in_tdata;
    end
    if (fire) begin
      out_res_r <= res;
    end
  end

  fupa_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .reg_sel (cfg_paddr[2]),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .cfg     (cfg)
  );

  fupa_alloc #(
    .MAX_UNITS (MAX_UNITS)
  ) u_alloc (
    .clk          (clk),
    .rst_n        (rst_n),
    .fire         (fire),
    .op           (s1_op_r),
    .handle       (s1_handle_r),
    .cfg          (cfg),
    .stk_top      (stk_top),
    .stk_nonempty (stk_nonempty),
    .res          (res),
    .stk_cmd      (stk_cmd),
    .push_unit    (push_unit)
  );

  fupa_stack #(
    .MAX_UNITS (MAX_UNITS)
  ) u_stack (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (stk_cmd),
    .push_unit (push_unit),
    .top       (stk_top),
    .nonempty  (stk_nonempty)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'd0, out_res_r};
  assign cfg_pready = 1'b1;

  // A waiting freed unit always satisfies an allocate.
  a_pop_succeeds: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && s1_op_r == OP_ALLOC && stk_nonempty) |-> (res.status == ST_OK))
    else $error("allocate failed although the free stack held a unit");

  // A successful free leaves at least one unit on the free stack.
  a_free_pushes: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && s1_op_r == OP_FREE && res.status == ST_OK) |=> stk_nonempty)
    else $error("free stack empty right after a successful free");

  // Back-pressure reaches the input only when both stages are full.
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> (s1_valid_r && out_valid_r && !out_tready))
    else $error("input stalled without a full pipeline");

endmodule

`default_nettype wire
